>>> rtl/smfir_pkg.sv
`timescale 1ns / 1ps
// Package for the stereo mix FIR lowpass unit: sizes, state encoding and
// the lowpass coefficient table. No dependencies.
package smfir_pkg;

    localparam int TAP_COUNT  = 42;
    localparam int LINE_DEPTH = 64;
    localparam int COEF_BITS  = 16;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 3;
    localparam int GAIN_MAX = (1 << GAIN_W) - 1;
    localparam int ROM_TAPS = 42;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int TAP_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int PROD_W = SAMPLE_W + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;
    localparam int SCL_W  = ACC_W + GAIN_MAX;
    localparam int FRAC_W = COEF_BITS - 1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3);

    localparam int COEF_Q15 [ROM_TAPS] = '{
        -223, -144, -174, -190, -190, -164, -105, -10, 121, 298,
        511, 757, 1032, 1324, 1622, 1914, 2182, 2415, 2605, 2733,
        2802, 2802, 2733, 2605, 2415, 2182, 1914, 1622, 1324, 1032,
        757, 511, 298, 121, -10, -105, -164, -190, -190, -174,
        -144, -223
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_OUT
    } state_t;

    // Coefficient at the configured width, rescaled from Q1.15 with
    // rounding half away from zero; taps past the table are zero.
    function automatic logic signed [COEF_BITS-1:0] coef_at(input int idx);
        longint v;
        longint r;
        r = 0;
        if (idx < ROM_TAPS)
        begin
            v = longint'(COEF_Q15[idx]) <<< FRAC_W;
            if (v >= 0)
            begin
                r = (v + 64'sd16384) >>> 15;
            end
            else
            begin
                r = -((-v + 64'sd16384) >>> 15);
            end
        end
        return COEF_BITS'(r);
    endfunction

endpackage

>>> rtl/stereo_mix_fir_lowpass_unit.sv
`timescale 1ns / 1ps
// Stereo mix FIR lowpass unit: mono mix, delay line in a RAM, one shared
// multiply-accumulate over all taps. Uses smfir_pkg and smfir_ram.
// A new input is accepted only when idle, after the previous result has been
// loaded for output: one multiply-accumulate per tap runs through the single
// read port of the delay RAM, and a stalled output holds the unit.
// Reset clears the delay line through per-entry valid bits, the write position
// and control state, and sets the gain shift to three.
module stereo_mix_fir_lowpass_unit
    import smfir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // filtered_sample [15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // gain_shift [2:0]
);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]          gain_reg;
    logic [ADDR_W-1:0]          pos_reg, pos_next;
    logic [TAP_W-1:0]           tap_reg, tap_next;
    logic signed [SAMPLE_W-1:0] mono_reg;
    logic [LINE_DEPTH-1:0]      valid_reg;

    logic                       rd_v_reg, rd_v_next;
    logic [TAP_W-1:0]           rd_idx_reg;
    logic                       rd_ok_reg;
    logic                       prod_v_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SCL_W-1:0]    scaled_reg;
    logic                       out_v_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic                       ram_we;
    logic                       out_load;
    logic                       last_tap;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] tap_sample;
    logic signed [COEF_BITS-1:0] tap_coef;
    logic signed [SAMPLE_W:0]   mix_sum;
    logic signed [SAMPLE_W:0]   mix_half;
    logic signed [SCL_W-1:0]    round_val;
    logic signed [SCL_W-1:0]    shr_val;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_reg;

    assign mix_sum  = {s_tdata[15], s_tdata[15:0]} + {s_tdata[31], s_tdata[31:16]};
    assign mix_half = (mix_sum + ((mix_sum < 0) ? 17'sd1 : 17'sd0)) >>> 1;

    assign last_tap = (tap_reg == TAP_W'(TAP_COUNT - 1));
    assign rd_addr  = (pos_reg >= ADDR_W'(tap_reg))
                      ? ADDR_W'(pos_reg - ADDR_W'(tap_reg))
                      : ADDR_W'(LINE_DEPTH + int'(pos_reg) - int'(tap_reg));

    assign tap_sample = rd_ok_reg ? $signed(ram_rdata) : '0;
    assign tap_coef   = coef_at(int'(rd_idx_reg));

    assign round_val = scaled_reg + ((scaled_reg < 0) ? SCL_W'((1 << FRAC_W) - 1) : '0);
    assign shr_val   = round_val >>> FRAC_W;
    assign sat_val   = (shr_val > SCL_W'(32767))  ? 16'sh7FFF :
                       (shr_val < -SCL_W'(32768)) ? 16'sh8000 :
                       SAMPLE_W'(shr_val);

    smfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (mono_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        tap_next   = tap_reg;
        rd_v_next  = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                tap_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                rd_v_next = 1'b1;
                tap_next  = tap_reg + TAP_W'(1);
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    pos_next   = (pos_reg == ADDR_W'(LINE_DEPTH - 1))
                                 ? '0 : pos_reg + ADDR_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            gain_reg   <= GAIN_RESET;
            pos_reg    <= '0;
            tap_reg    <= '0;
            valid_reg  <= '0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            tap_reg    <= tap_next;
            rd_v_reg   <= rd_v_next;
            prod_v_reg <= rd_v_reg;
            if (cfg_valid && cfg_ready)
            begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
            if (ram_we)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mono_reg <= SAMPLE_W'(mix_half);
        end
        rd_idx_reg <= tap_reg;
        rd_ok_reg  <= valid_reg[rd_addr];
        prod_reg   <= tap_sample * tap_coef;
        if (ram_we)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_SCALE)
        begin
            scaled_reg <= SCL_W'(acc_reg) <<< gain_reg;
        end
        if (out_load)
        begin
            out_reg <= sat_val;
        end
    end

    a_write_then_mac: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == ST_MAC) && valid_reg[$past(pos_reg)])
        else $error("Delay line write not followed by the tap sweep.");

    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (int'(tap_reg) < TAP_COUNT))
        else $error("Tap counter beyond the tap count.");

    a_drained_before_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> (!rd_v_reg && !prod_v_reg))
        else $error("Scaling started with products still in flight.");

    a_load_advances_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && (state_reg == ST_IDLE) && (pos_reg != $past(pos_reg)))
        else $error("Result load did not advance the write position.");

endmodule

>>> rtl/smfir_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sim/smfir_checker.sv
`timescale 1ns / 1ps
// Checker for stereo_mix_fir_lowpass_unit: watches the sample, result and gain
// channels, predicts every filtered sample and compares it with the output.
// Standalone module; no package or RTL dependency.
module smfir_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // filtered_sample [15:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,  // gain_shift [2:0]
    output int          fail_count,
    output int          pending
);

    localparam int TAPS         = 42;
    localparam int HISTORY      = 64;
    localparam int FRAC_BITS    = 15;
    localparam int REPORT_LIMIT = 10;
    localparam logic [2:0] GAIN_DEFAULT = 3'd3;

    localparam int LOWPASS_TAPS [TAPS] = '{
        -223, -144, -174, -190, -190, -164, -105, -10, 121, 298,
        511, 757, 1032, 1324, 1622, 1914, 2182, 2415, 2605, 2733,
        2802, 2802, 2733, 2605, 2415, 2182, 1914, 1622, 1324, 1032,
        757, 511, 298, 121, -10, -105, -164, -190, -190, -174,
        -144, -223
    };

    logic signed [15:0] mono_history [HISTORY];
    logic [5:0]         wr_head;
    logic [2:0]         gain_shift;
    logic [15:0]        expected_samples [$];
    logic [15:0]        want;
    int                 k;

    // Mixes the pair down to mono, stores it and runs the filter over the
    // newest samples; the sum keeps full precision until the final shift and clamp.
    function automatic logic [15:0] lowpass_next(input logic signed [15:0] l_smp,
                                                 input logic signed [15:0] r_smp);
        int         mono;
        longint     acc;
        longint     res;
        logic [5:0] idx;
        int         t;
        mono = (int'(l_smp) + int'(r_smp)) / 2;
        mono_history[wr_head] = 16'(mono);
        acc = 0;
        for (t = 0; t < TAPS; t++)
        begin
            idx = wr_head - 6'(t);
            acc += longint'(mono_history[idx]) * longint'(LOWPASS_TAPS[t]);
        end
        acc = acc <<< gain_shift;
        if (acc < 0)
        begin
            res = -((-acc) >>> FRAC_BITS);
        end
        else
        begin
            res = acc >>> FRAC_BITS;
        end
        if (res > 32767)
        begin
            res = 32767;
        end
        if (res < -32768)
        begin
            res = -32768;
        end
        wr_head = wr_head + 6'd1;
        return 16'(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < HISTORY; k++)
            begin
                mono_history[k] = '0;
            end
            wr_head = '0;
            gain_shift = GAIN_DEFAULT;
            expected_samples.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gain_shift = cfg_data[2:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected output transfer, got %0d",
                                 $time, $signed(m_tdata));
                    end
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display("%0t: filtered_sample mismatch, expected %0d, got %0d",
                                     $time, $signed(want), $signed(m_tdata));
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_samples.push_back(lowpass_next(s_tdata[15:0], s_tdata[31:16]));
            end
            pending = expected_samples.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for stereo_mix_fir_lowpass_unit: clock, reset, sample pair and
// gain stimulus, output back-pressure, watchdog and verdict.
// Depends on the unit's RTL and on smfir_checker.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 229;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 60;
    localparam int IDLE_PAD       = 8;
    localparam logic [2:0] GAIN_PLAN [PHASES] = '{
        3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4, 3'd3
    };
    localparam logic [15:0] POS_RAIL = 16'h7FFF;
    localparam logic [15:0] NEG_RAIL = 16'h8000;

    typedef enum int {
        RUN_NOISE,
        RUN_RAIL,
        RUN_QUIET,
        RUN_LEVEL
    } run_style_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int          fail_count;
    int          pending;
    bit          src_eager;
    bit          sink_eager;
    logic        result_taken;
    int          stall_left;
    int          idle_cycles;
    int          run_left;
    run_style_t  run_style;
    logic [15:0] run_level;
    logic [15:0] l_next;
    logic [15:0] r_next;
    int          p;
    int          i;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stereo_mix_fir_lowpass_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    smfir_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_pair(input logic [15:0] l_smp, input logic [15:0] r_smp);
        int gap;
        gap = src_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {r_smp, l_smp};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (IDLE_PAD) @(negedge clk);
    endtask

    task automatic write_gain(input logic [2:0] g);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= {5'($urandom), g};
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random pairs come in runs: wideband noise, runs pinned near a rail that
    // drive the output into saturation, quiet signals and a held level.
    task automatic next_random_pair(output logic [15:0] l_smp, output logic [15:0] r_smp);
        if (run_left == 0)
        begin
            run_left = $urandom_range(1, 60);
            run_style = run_style_t'($urandom_range(0, 3));
            run_level = 16'($urandom);
        end
        run_left--;
        case (run_style)
            RUN_RAIL:
            begin
                if (run_level[15])
                begin
                    l_smp = NEG_RAIL | 16'($urandom_range(0, 3));
                    r_smp = NEG_RAIL | 16'($urandom_range(0, 3));
                end
                else
                begin
                    l_smp = POS_RAIL ^ 16'($urandom_range(0, 3));
                    r_smp = POS_RAIL ^ 16'($urandom_range(0, 3));
                end
            end
            RUN_QUIET:
            begin
                l_smp = 16'($urandom_range(0, 511) - 256);
                r_smp = 16'($urandom_range(0, 511) - 256);
            end
            RUN_LEVEL:
            begin
                l_smp = run_level ^ 16'($urandom_range(0, 15));
                r_smp = run_level ^ 16'($urandom_range(0, 15));
            end
            default:
            begin
                l_smp = 16'($urandom);
                r_smp = 16'($urandom);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_taken <= 1'b0;
        end
        else
        begin
            result_taken <= m_tvalid && m_tready;
        end
    end

    // The stall for each result counts only while the result is offered.
    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (result_taken)
            begin
                stall_left = sink_eager ? 0 : $urandom_range(0, 7);
                m_tready <= (stall_left == 0);
            end
            else if (m_tvalid && !m_tready)
            begin
                if (stall_left == 0)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    stall_left--;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAIL stereo_mix_fir_lowpass_unit");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        src_eager = 1'b0;
        sink_eager = 1'b0;
        run_left = 0;
        run_style = RUN_NOISE;
        run_level = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset gain, starting on a cleared history:
        // halving rounds toward zero, then both rails, then opposite rails.
        send_pair(16'd1, 16'd0);
        send_pair(16'hFFFF, 16'd0);
        send_pair(16'hFFFD, 16'd0);
        for (i = 0; i < 16; i++)
        begin
            send_pair(POS_RAIL, POS_RAIL);
        end
        for (i = 0; i < 4; i++)
        begin
            send_pair(NEG_RAIL, NEG_RAIL | 16'd1);
        end
        send_pair(POS_RAIL, NEG_RAIL);
        send_pair(NEG_RAIL, POS_RAIL);

        for (p = 0; p < PHASES; p++)
        begin
            write_gain(GAIN_PLAN[p]);
            src_eager = (p == 2) || ($urandom_range(0, 3) == 0);
            sink_eager = (p == 5) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                begin
                    drain_results();
                end
                next_random_pair(l_next, r_next);
                send_pair(l_next, r_next);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS stereo_mix_fir_lowpass_unit");
        end
        else
        begin
            $display("FAIL stereo_mix_fir_lowpass_unit");
        end
        $finish;
    end

endmodule

>>> stereo_mix_fir_lowpass_unit.f
rtl/smfir_pkg.sv
rtl/smfir_ram.sv
rtl/stereo_mix_fir_lowpass_unit.sv
sim/smfir_checker.sv
sim/tb.sv
